### src/i2a_pkg.sv
// i2a_pkg: shared types, codes and character helpers for the integer to ASCII formatter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package i2a_pkg;

	typedef struct packed {
		logic [2:0]  action;
		logic [63:0] value;
	} in_word_t;

	typedef struct packed {
		logic [7:0]  ascii_char;
		logic        last_char;
		logic [31:0] running_count;
	} out_word_t;

	// action codes on the input word
	localparam logic [2:0] ACT_SDEC   = 3'd0;
	localparam logic [2:0] ACT_UDEC   = 3'd1;
	localparam logic [2:0] ACT_HEX_LO = 3'd2;
	localparam logic [2:0] ACT_HEX_UP = 3'd3;
	localparam logic [2:0] ACT_PTR    = 3'd4;

	// what the back end has to do with a queued word
	typedef enum logic [2:0] {
		KIND_DEC,
		KIND_HEX_LO,
		KIND_HEX_UP,
		KIND_PTR,
		KIND_NIL
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic  neg;
	} fmt_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_PRE,
		ST_DIGIT
	} back_state_t;

	localparam int DEC_DIGITS  = 10;
	localparam int QUEUE_DEPTH = 2;

	// floor(v / 10) == (v * RECIP_10) >> RECIP_SHIFT for every 32-bit v
	localparam logic [31:0] RECIP_10    = 32'hCCCCCCCD;
	localparam int          RECIP_SHIFT = 35;

	function automatic logic [7:0] prefix_char(kind_t kind, logic [2:0] pos);
		logic [7:0] c;
		case (kind)
			KIND_PTR: c = (pos == 3'd0) ? 8'h30 : 8'h78;
			KIND_NIL: begin
				case (pos)
					3'd0:    c = 8'h28;
					3'd1:    c = 8'h6E;
					3'd2:    c = 8'h69;
					3'd3:    c = 8'h6C;
					default: c = 8'h29;
				endcase
			end
			default:  c = 8'h2D;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] digit_char(logic [3:0] d, logic upper);
		logic [7:0] c;
		if (d < 4'd10)
			c = 8'h30 + {4'b0, d};
		else if (upper)
			c = 8'h37 + {4'b0, d};
		else
			c = 8'h57 + {4'b0, d};
		return c;
	endfunction

endpackage

### src/i2a_front.sv
// i2a_front: takes input words, classifies them and prepares the magnitude and hex digit count.
// Depends on i2a_pkg.
`timescale 1ns / 1ps

module i2a_front
	import i2a_pkg::*;
#(
	parameter int POINTER_BITS = 64,
	parameter int VAL_W        = 64,
	parameter int CNT_W        = 5
) (
	input  logic             in_valid,
	output logic             in_stall,
	input  in_word_t         in_data,
	input  logic             full,
	output logic             push,
	output fmt_ctl_t         push_ctl,
	output logic [VAL_W-1:0] push_mag,
	output logic [CNT_W-1:0] push_ndig
);

	localparam int NV = VAL_W / 4;

	logic [31:0]             low;
	logic [POINTER_BITS-1:0] ptr;
	logic                    known;

	assign low = in_data.value[31:0];
	assign ptr = in_data.value[POINTER_BITS-1:0];

	always_comb begin
		push_ctl.kind = KIND_DEC;
		push_ctl.neg  = 1'b0;
		push_mag      = '0;
		known         = 1'b1;
		case (in_data.action)
			ACT_SDEC: begin
				push_ctl.neg = low[31];
				push_mag     = VAL_W'(low[31] ? (32'd0 - low) : low);
			end
			ACT_UDEC: push_mag = VAL_W'(low);
			ACT_HEX_LO: begin
				push_ctl.kind = KIND_HEX_LO;
				push_mag      = VAL_W'(low);
			end
			ACT_HEX_UP: begin
				push_ctl.kind = KIND_HEX_UP;
				push_mag      = VAL_W'(low);
			end
			ACT_PTR: begin
				push_ctl.kind = (ptr == '0) ? KIND_NIL : KIND_PTR;
				push_mag      = VAL_W'(ptr);
			end
			default: known = 1'b0;
		endcase
	end

	// significant hex digits; zero still prints one
	always_comb begin
		push_ndig = CNT_W'(1);
		for (int i = 1; i < NV; i++) begin
			if (push_mag[4*i +: 4] != 4'd0)
				push_ndig = CNT_W'(i + 1);
		end
	end

	assign in_stall = full;
	assign push     = in_valid && !full && known;

endmodule

### src/i2a_queue.sv
// i2a_queue: short FIFO between the classifying front end and the emitting back end.
// Depends on i2a_pkg for its depth.
`timescale 1ns / 1ps

module i2a_queue
	import i2a_pkg::*;
#(
	parameter int W = 72
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic         valid,
	output logic [W-1:0] dout
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [W-1:0]     mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wptr_q, rptr_q;
	logic [CNT_W-1:0] cnt_q;

	function automatic logic [PTR_W-1:0] bump(logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign full  = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign valid = (cnt_q != '0);
	assign dout  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wptr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push)
				wptr_q <= bump(wptr_q);
			if (pop)
				rptr_q <= bump(rptr_q);
			if (push && !pop)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

endmodule

### src/i2a_back.sv
// i2a_back: converts a queued word to digits and emits its characters one per cycle while the output is not stalled.
// Depends on i2a_pkg; fed by i2a_queue.
`timescale 1ns / 1ps

module i2a_back
	import i2a_pkg::*;
#(
	parameter int VAL_W     = 64,
	parameter int CNT_W     = 5,
	parameter int BUF_DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  fmt_ctl_t         q_ctl,
	input  logic [VAL_W-1:0] q_mag,
	input  logic [CNT_W-1:0] q_ndig,
	output logic             q_pop,
	output logic             out_valid,
	input  logic             out_stall,
	output out_word_t        out_data
);

	localparam int IDX_W = $clog2(BUF_DEPTH);
	localparam int LDW   = 4 * BUF_DEPTH;

	back_state_t      st_q, st_nxt;
	kind_t            kind_q;
	logic             neg_q;
	logic [VAL_W-1:0] val_q;
	logic [3:0]       buf_q [BUF_DEPTH];
	logic [CNT_W-1:0] ndig_q;
	logic [IDX_W-1:0] idx_q;
	logic [2:0]       pre_q;
	logic             out_valid_q;
	out_word_t        out_q;
	logic [31:0]      count_q;

	logic             can_emit, emit, last, pre_done;
	logic [7:0]       ch;
	logic [LDW-1:0]   ldv;
	logic [63:0]      prod;
	logic [28:0]      quo;
	logic [31:0]      rem;

	assign can_emit = !out_valid_q || !out_stall;
	assign ldv      = LDW'(q_mag);

	// one decimal digit per cycle by reciprocal multiply
	assign prod = {32'b0, val_q[31:0]} * {32'b0, RECIP_10};
	assign quo  = prod[63:RECIP_SHIFT];
	assign rem  = val_q[31:0] - ({quo, 3'b0} + {2'b0, quo, 1'b0});

	always_comb begin
		case (kind_q)
			KIND_NIL: pre_done = (pre_q == 3'd4);
			KIND_PTR: pre_done = (pre_q == 3'd1);
			default:  pre_done = 1'b1;
		endcase
	end

	// next state
	always_comb begin
		st_nxt = st_q;
		case (st_q)
			ST_IDLE: begin
				if (q_valid) begin
					case (q_ctl.kind)
						KIND_DEC:           st_nxt = ST_CONV;
						KIND_PTR, KIND_NIL: st_nxt = ST_PRE;
						default:            st_nxt = ST_DIGIT;
					endcase
				end
			end
			ST_CONV: begin
				if (quo == '0)
					st_nxt = neg_q ? ST_PRE : ST_DIGIT;
			end
			ST_PRE: begin
				if (emit && pre_done)
					st_nxt = (kind_q == KIND_NIL) ? ST_IDLE : ST_DIGIT;
			end
			ST_DIGIT: begin
				if (emit && idx_q == '0)
					st_nxt = ST_IDLE;
			end
			default: st_nxt = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		q_pop = 1'b0;
		emit  = 1'b0;
		ch    = 8'h30;
		last  = 1'b0;
		case (st_q)
			ST_IDLE: q_pop = q_valid;
			ST_PRE: begin
				emit = can_emit;
				ch   = prefix_char(kind_q, pre_q);
				last = (kind_q == KIND_NIL) && pre_done;
			end
			ST_DIGIT: begin
				emit = can_emit;
				ch   = digit_char(buf_q[idx_q], kind_q == KIND_HEX_UP);
				last = (idx_q == '0);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				if (q_valid) begin
					kind_q <= q_ctl.kind;
					neg_q  <= q_ctl.neg;
					val_q  <= q_mag;
					ndig_q <= '0;
					idx_q  <= IDX_W'(q_ndig - CNT_W'(1));
					pre_q  <= '0;
					for (int i = 0; i < BUF_DEPTH; i++)
						buf_q[i] <= ldv[4*i +: 4];
				end
			end
			ST_CONV: begin
				buf_q[ndig_q[IDX_W-1:0]] <= rem[3:0];
				ndig_q <= ndig_q + CNT_W'(1);
				val_q  <= VAL_W'(quo);
				if (quo == '0)
					idx_q <= ndig_q[IDX_W-1:0];
			end
			ST_PRE: begin
				if (emit)
					pre_q <= pre_q + 3'd1;
			end
			ST_DIGIT: begin
				if (emit)
					idx_q <= idx_q - IDX_W'(1);
			end
			default: ;
		endcase
		if (emit) begin
			out_q.ascii_char    <= ch;
			out_q.last_char     <= last;
			out_q.running_count <= count_q + 32'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			out_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			st_q <= st_nxt;
			if (emit) begin
				out_valid_q <= 1'b1;
				count_q     <= count_q + 32'd1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

### src/integer_to_ascii_formatter_top.sv
// Integer to ASCII formatter, top level: front end, word queue and emitting back end.
// Depends on i2a_pkg, i2a_front, i2a_queue and i2a_back.
`timescale 1ns / 1ps

// Prints one number per input word as ASCII, most significant character first, one
// character per output word with a running count since reset and a flag on the last one.
// The front end holds up to two words ahead in the queue; undefined actions are dropped
// there. The back end takes a word, then for decimal converts it to digits (a 32x32
// reciprocal multiply by one tenth), then emits its characters: a minus sign first when
// negative, "0x" before a pointer, and "(nil)" for a null pointer.
// A stall on the output holds the back end; the front end keeps filling the queue.

module integer_to_ascii_formatter_top
	import i2a_pkg::*;
#(
	parameter int POINTER_BITS = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_word_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_word_t out_data
);

	localparam int NIB       = (POINTER_BITS + 3) / 4;
	localparam int VAL_W     = (NIB * 4 > 32) ? NIB * 4 : 32;
	localparam int BUF_DEPTH = (NIB > DEC_DIGITS) ? NIB : DEC_DIGITS;
	localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
	localparam int QW        = $bits(fmt_ctl_t) + CNT_W + VAL_W;

	logic             push, full, pop, q_valid;
	fmt_ctl_t         push_ctl, q_ctl;
	logic [VAL_W-1:0] push_mag, q_mag;
	logic [CNT_W-1:0] push_ndig, q_ndig;
	logic [QW-1:0]    q_dout;

	i2a_front #(
		.POINTER_BITS(POINTER_BITS),
		.VAL_W       (VAL_W),
		.CNT_W       (CNT_W)
	) u_front (
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.full     (full),
		.push     (push),
		.push_ctl (push_ctl),
		.push_mag (push_mag),
		.push_ndig(push_ndig)
	);

	i2a_queue #(
		.W(QW)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   ({push_ctl, push_ndig, push_mag}),
		.full  (full),
		.pop   (pop),
		.valid (q_valid),
		.dout  (q_dout)
	);

	assign {q_ctl, q_ndig, q_mag} = q_dout;

	i2a_back #(
		.VAL_W    (VAL_W),
		.CNT_W    (CNT_W),
		.BUF_DEPTH(BUF_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_ctl    (q_ctl),
		.q_mag    (q_mag),
		.q_ndig   (q_ndig),
		.q_pop    (pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

endmodule

### src/i2a_checker.sv
// i2a_checker: port-level checks on the formatter's output words, bound to the top level.
// Depends on i2a_pkg and integer_to_ascii_formatter_top.
`timescale 1ns / 1ps

module i2a_checker
	import i2a_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      out_valid,
	input logic      out_stall,
	input out_word_t out_data
);

	logic        seen_q;
	logic [31:0] last_cnt_q;
	logic        out_take;

	assign out_take = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q     <= 1'b0;
			last_cnt_q <= '0;
		end else if (out_take) begin
			seen_q     <= 1'b1;
			last_cnt_q <= out_data.running_count;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("output word changed while stalled");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_take && seen_q |-> out_data.running_count == last_cnt_q + 32'd1)
		else $error("running count did not advance by one");

	a_first_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_take && !seen_q |-> out_data.running_count == 32'd1)
		else $error("first word after reset does not count one");

	a_last_not_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.last_char |->
			out_data.ascii_char != 8'h2D && out_data.ascii_char != 8'h28 &&
			out_data.ascii_char != 8'h78)
		else $error("run ended on a prefix character");

	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.ascii_char >= 8'h28 && out_data.ascii_char <= 8'h78)
		else $error("character outside the formatter's set");

endmodule

bind integer_to_ascii_formatter_top i2a_checker u_i2a_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_data (out_data)
);
